// ----- sv/cqpe_pkg.sv -----
// ----------------------------------------------------------------------------
// cqpe_pkg
// Shared types and codes for the compacting queue with priority extract.
// ----------------------------------------------------------------------------
`default_nettype none

package cqpe_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int MAX_OUT   = 16;
    localparam int NOUT_W    = $clog2(MAX_OUT + 1);

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_EXTRACT = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    localparam logic [7:0] PRIO_ONE   = 8'd1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] entry_tag;
        logic [7:0]  entry_priority;
        logic [3:0]  slot_index;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_tag;
        logic [7:0]  out_priority;
        logic [3:0]  out_slot;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [15:0] tag;
        logic [7:0]  prio;
    } t_entry;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- sv/compacting_queue_with_priority_extract.sv -----
// ----------------------------------------------------------------------------
// compacting_queue_with_priority_extract
// Packed queue of tag/priority words held in a row of cells, with push,
// remove at slot and extract of every priority-one word.
// Push and remove: result in the cycle after acceptance, busy stays low, one
// command per cycle. Extract: busy while the scan runs; each scan step either
// removes a word or steps one cell, and each found word is held until the
// next find or the end of the scan.
// Reset (synchronous, active low) empties the queue and drops any result.
// ----------------------------------------------------------------------------
`default_nettype none

module compacting_queue_with_priority_extract
    import cqpe_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      start,
    output logic     busy,
    input  t_cmd     i_cmd,
    output logic     o_valid,
    output t_result  o_result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = (CW > 4) ? CW : 4;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_ptr, n_ptr;
    logic [NOUT_W-1:0]   r_nout, n_nout;
    logic                r_have, n_have;
    t_result             r_pend, n_pend;
    logic                r_valid, n_valid;
    t_result             r_result, n_result;

    t_entry              w_cell [DEPTH];
    t_entry              w_push;
    logic                w_push_en;
    logic                w_rm_en;
    logic [CW-1:0]       w_rm_idx;
    logic [XW-1:0]       w_slot_x;
    logic [XW-1:0]       w_count_x;
    logic [XW-1:0]       w_ptr_x;
    t_entry              w_sel_slot;
    t_entry              w_sel_ptr;

    assign w_push.tag  = i_cmd.entry_tag;
    assign w_push.prio = i_cmd.entry_priority;
    assign w_slot_x    = XW'(i_cmd.slot_index);
    assign w_count_x   = XW'(r_count);
    assign w_ptr_x     = XW'(r_ptr);
    assign w_sel_slot  = w_cell[w_slot_x[IW-1:0]];
    assign w_sel_ptr   = w_cell[r_ptr[IW-1:0]];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_cell_ctrl w_ctrl;
            t_entry     w_next;

            assign w_ctrl.load  = w_push_en && (r_count == CW'(gi));
            assign w_ctrl.shift = w_rm_en && (CW'(gi) >= w_rm_idx);

            if (gi == DEPTH - 1) begin : g_end
                assign w_next = '0;
            end else begin : g_mid
                assign w_next = w_cell[gi + 1];
            end

            cqpe_cell u_cell (
                .i_clk  (i_clk),
                .i_ctrl (w_ctrl),
                .i_push (w_push),
                .i_next (w_next),
                .o_data (w_cell[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_nout    = r_nout;
        n_have    = r_have;
        n_pend    = r_pend;
        n_valid   = 1'b0;
        n_result  = r_result;
        w_push_en = 1'b0;
        w_rm_en   = 1'b0;
        w_rm_idx  = r_ptr;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_cmd.opcode)
                        OP_PUSH: begin
                            n_valid = 1'b1;
                            n_result = '0;
                            n_result.last = 1'b1;
                            if (r_count >= CW'(DEPTH)) begin
                                n_result.status = ST_FULL;
                            end else begin
                                n_result.status       = ST_OK;
                                n_result.out_tag      = i_cmd.entry_tag;
                                n_result.out_priority = i_cmd.entry_priority;
                                n_result.out_slot     = w_count_x[3:0];
                                w_push_en = 1'b1;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            n_valid = 1'b1;
                            n_result = '0;
                            n_result.last = 1'b1;
                            if (w_slot_x >= w_count_x) begin
                                n_result.status = ST_INVALID;
                            end else begin
                                n_result.status       = ST_OK;
                                n_result.out_tag      = w_sel_slot.tag;
                                n_result.out_priority = w_sel_slot.prio;
                                n_result.out_slot     = i_cmd.slot_index;
                                w_rm_en  = 1'b1;
                                w_rm_idx = w_slot_x[CW-1:0];
                                n_count  = r_count - 1'b1;
                            end
                        end
                        OP_EXTRACT: begin
                            n_state = S_SCAN;
                            n_ptr   = '0;
                            n_nout  = '0;
                            n_have  = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if ((r_ptr >= r_count) || (r_nout == NOUT_W'(MAX_OUT))) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (r_have) begin
                        n_result      = r_pend;
                        n_result.last = 1'b1;
                    end else begin
                        n_result        = '0;
                        n_result.status = ST_NONE;
                        n_result.last   = 1'b1;
                    end
                end else if (w_sel_ptr.prio == PRIO_ONE) begin
                    if (r_have) begin
                        n_valid  = 1'b1;
                        n_result = r_pend;
                    end
                    n_pend.status       = ST_OK;
                    n_pend.out_tag      = w_sel_ptr.tag;
                    n_pend.out_priority = w_sel_ptr.prio;
                    n_pend.out_slot     = w_ptr_x[3:0];
                    n_pend.last         = 1'b0;
                    n_have  = 1'b1;
                    n_nout  = r_nout + 1'b1;
                    w_rm_en = 1'b1;
                    n_count = r_count - 1'b1;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_have  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_have  <= n_have;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_nout   <= n_nout;
        r_pend   <= n_pend;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- sv/cqpe_cell.sv -----
// ----------------------------------------------------------------------------
// cqpe_cell
// One slot of the queue: loads a pushed word or takes its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module cqpe_cell
    import cqpe_pkg::*;
(
    input  wire         i_clk,
    input  t_cell_ctrl  i_ctrl,
    input  t_entry      i_push,
    input  t_entry      i_next,
    output t_entry      o_data
);

    t_entry r_data;
    t_entry n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.shift) begin
            n_data = i_next;
        end else if (i_ctrl.load) begin
            n_data = i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ----- sv/cqpe_checker.sv -----
// ----------------------------------------------------------------------------
// cqpe_checker
// Port-level checks on command completion and result marking.
// ----------------------------------------------------------------------------
`default_nettype none

module cqpe_checker
    import cqpe_pkg::*;
(
    input wire      i_clk,
    input wire      i_rst_n,
    input wire      start,
    input wire      busy,
    input t_cmd     i_cmd,
    input wire      o_valid,
    input t_result  o_result
);

    // single word commands answer on the next cycle
    a_single_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.opcode == OP_PUSH || i_cmd.opcode == OP_REMOVE))
        |=> (o_valid && o_result.last))
        else $error("push or remove without a final word on the next cycle");

    a_extract_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.opcode == OP_EXTRACT) |=> busy)
        else $error("extract accepted without going busy");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |-> busy)
        else $error("non-final word outside an extract");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |-> !busy)
        else $error("final word while still busy");

    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_NONE) |-> o_result.last)
        else $error("none-found word without final mark");

endmodule

bind compacting_queue_with_priority_extract cqpe_checker u_cqpe_checker (.*);

`default_nettype wire

// ----- bench/tb_compacting_queue_with_priority_extract.sv -----
// ----------------------------------------------------------------------------
// tb_compacting_queue_with_priority_extract
// Drives push, remove-at-slot, extract and unused commands into the queue
// with random gaps. A scoreboard keeps its own copy of the queue, predicts
// every result word and checks each one against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_compacting_queue_with_priority_extract;
    import cqpe_pkg::*;

    localparam int         QUEUE_DEPTH = DEPTH_DEF;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    class queue_tracker;
        t_entry  entries[$];
        t_result pending[$];
        int      errors;

        function void note_cmd(t_cmd c);
            t_result r;
            t_result held;
            bit      have_held;
            int      n;
            int      i;
            t_entry  e;
            r = '0;
            r.last = 1'b1;
            have_held = 1'b0;
            n = 0;
            i = 0;
            case (c.opcode)
                OP_PUSH: begin
                    if (entries.size() >= QUEUE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        e.tag = c.entry_tag;
                        e.prio = c.entry_priority;
                        entries.push_back(e);
                        r.status = ST_OK;
                        r.out_tag = c.entry_tag;
                        r.out_priority = c.entry_priority;
                        r.out_slot = 4'(entries.size() - 1);
                    end
                    pending.push_back(r);
                end
                OP_REMOVE: begin
                    if (int'(c.slot_index) >= entries.size()) begin
                        r.status = ST_INVALID;
                    end else begin
                        e = entries[c.slot_index];
                        entries.delete(int'(c.slot_index));
                        r.status = ST_OK;
                        r.out_tag = e.tag;
                        r.out_priority = e.prio;
                        r.out_slot = c.slot_index;
                    end
                    pending.push_back(r);
                end
                OP_EXTRACT: begin
                    while (i < entries.size() && n < MAX_OUT) begin
                        if (entries[i].prio == PRIO_ONE) begin
                            if (have_held) pending.push_back(held);
                            held = '0;
                            held.status = ST_OK;
                            held.out_tag = entries[i].tag;
                            held.out_priority = entries[i].prio;
                            held.out_slot = 4'(i);
                            have_held = 1'b1;
                            entries.delete(i);
                            n++;
                        end else begin
                            i++;
                        end
                    end
                    if (have_held) begin
                        held.last = 1'b1;
                        pending.push_back(held);
                    end else begin
                        r.status = ST_NONE;
                        pending.push_back(r);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_word(t_result got);
            t_result exp;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected word st=%0d tag=%h pri=%h slot=%0d last=%0b",
                         $time, got.status, got.out_tag, got.out_priority,
                         got.out_slot, got.last);
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status || got.out_tag !== exp.out_tag ||
                got.out_priority !== exp.out_priority ||
                got.out_slot !== exp.out_slot || got.last !== exp.last) begin
                errors++;
                $display("%0t: mismatch expected st=%0d tag=%h pri=%h slot=%0d last=%0b",
                         $time, exp.status, exp.out_tag, exp.out_priority,
                         exp.out_slot, exp.last);
                $display("%0t:          got      st=%0d tag=%h pri=%h slot=%0d last=%0b",
                         $time, got.status, got.out_tag, got.out_priority,
                         got.out_slot, got.last);
            end
        endfunction
    endclass

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_cmd    i_cmd = '0;
    logic    o_valid;
    t_result o_result;

    queue_tracker sb = new;
    int           issued = 0;
    bit           steady = 1'b1;

    compacting_queue_with_priority_extract dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_cmd(i_cmd);
        if (i_rst_n && o_valid) sb.check_word(o_result);
    end

    // hold start until the word is taken, then maybe idle
    task automatic send_word(t_cmd c);
        int gap;
        int pick;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        issued++;
        pick = $urandom_range(0, 99);
        if (steady || pick < 50) gap = 0;
        else if (pick < 85) gap = $urandom_range(1, 3);
        else if (pick < 97) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            start <= 1'b0;
            i_cmd <= t_cmd'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic push_entry(logic [15:0] tag, logic [7:0] prio);
        t_cmd c;
        c = t_cmd'($urandom);
        c.opcode = OP_PUSH;
        c.entry_tag = tag;
        c.entry_priority = prio;
        send_word(c);
    endtask

    task automatic remove_at(logic [3:0] slot);
        t_cmd c;
        c = t_cmd'($urandom);
        c.opcode = OP_REMOVE;
        c.slot_index = slot;
        send_word(c);
    endtask

    task automatic extract_ones();
        t_cmd c;
        c = t_cmd'($urandom);
        c.opcode = OP_EXTRACT;
        send_word(c);
    endtask

    task automatic send_unused();
        t_cmd c;
        c = t_cmd'($urandom);
        c.opcode = OP_UNUSED;
        send_word(c);
    endtask

    initial begin
        #2000000;
        $display("tb_compacting_queue_with_priority_extract: done, errors");
        $finish;
    end

    initial begin
        logic [7:0] fill_prio [16];
        int         pick;
        int         cnt;
        fill_prio = '{8'd1, 8'd0, 8'd255, 8'd1, 8'd1, 8'd2, 8'd1, 8'd128,
                      8'd127, 8'd1, 8'd0, 8'd1, 8'd254, 8'd1, 8'd3, 8'd1};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue, unused opcode, fill, overflow, edge slots, extract
        remove_at(4'd0);
        extract_ones();
        send_unused();
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            push_entry((k == 0) ? 16'hFFFF : (k == 1) ? 16'h0000 : 16'($urandom),
                       fill_prio[k]);
        end
        push_entry(16'($urandom), 8'($urandom));
        remove_at(4'd15);
        remove_at(4'd15);
        remove_at(4'd0);
        extract_ones();
        extract_ones();

        while (issued < 130) begin
            if (issued % 25 == 0) steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            cnt = sb.entries.size();
            if (pick < 4) begin
                repeat (QUEUE_DEPTH - cnt) push_entry(16'($urandom), PRIO_ONE);
                extract_ones();
            end else if (pick < 45) begin
                push_entry(16'($urandom),
                           ($urandom_range(0, 2) == 0) ? PRIO_ONE : 8'($urandom));
            end else if (pick < 75) begin
                if (cnt == 0 || $urandom_range(0, 4) == 0)
                    remove_at(4'($urandom_range(0, 15)));
                else
                    remove_at(4'($urandom_range(0, cnt - 1)));
            end else if (pick < 94) begin
                extract_ones();
            end else begin
                send_unused();
            end
        end

        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_compacting_queue_with_priority_extract: done, clean");
        else
            $display("tb_compacting_queue_with_priority_extract: done, errors");
        $finish;
    end

endmodule
